[hw/rtl/log_flush_scheduler_assert.svh]
// Assertion helpers used by the scheduler RTL
`ifndef LOG_FLUSH_SCHEDULER_ASSERT_SVH
`define LOG_FLUSH_SCHEDULER_ASSERT_SVH

// checked outside reset
`define LFS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define LFS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/lfs_pkg.sv]
package lfs_pkg;

   localparam int TIME_W    = 32;
   localparam int USED_W    = 16;
   localparam int REC_W     = 16;
   localparam int OP_W      = 3;
   localparam int CAP_W     = 16;
   localparam int PCT_W     = 7;
   localparam int BACKOFF_W = 20;
   localparam int DL_W      = 27;
   localparam int PROD_W    = CAP_W + PCT_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 27;

   localparam logic [CAP_W-1:0]     RST_RING_CAPACITY = CAP_W'(4096);
   localparam logic [PCT_W-1:0]     RST_NORMAL_PCT    = PCT_W'(50);
   localparam logic [PCT_W-1:0]     RST_EMERG_PCT     = PCT_W'(90);
   localparam logic [BACKOFF_W-1:0] RST_BACKOFF_MS    = BACKOFF_W'(5000);
   localparam logic [DL_W-1:0]      RST_FIRST_MS      = DL_W'(0);
   localparam logic [DL_W-1:0]      RST_FAILSAFE_MS   = DL_W'(3600000);
   localparam logic [PROD_W-1:0]    RST_PROD_NORMAL   = PROD_W'(4096 * 50);
   localparam logic [PROD_W-1:0]    RST_PROD_EMERG    = PROD_W'(4096 * 90);

   // threshold compares are done as used*100 + 99 >= capacity*percent
   localparam logic [PROD_W-1:0] PCT_SCALE = PROD_W'(100);
   localparam logic [PROD_W-1:0] PCT_ROUND = PROD_W'(99);

   localparam logic [TIME_W-1:0] WAIT_NEVER = '1;
   localparam logic [TIME_W-1:0] WAIT_NOW   = TIME_W'(1);

   typedef enum logic [OP_W-1:0] {
      OP_TICK       = 3'd0,
      OP_OUTCOME    = 3'd1,
      OP_WRITE_FAIL = 3'd2,
      OP_GW_BEGIN   = 3'd3,
      OP_GW_END     = 3'd4,
      OP_GW_DRAINED = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      REASON_NONE     = 2'd0,
      REASON_NORMAL   = 2'd1,
      REASON_EMERG    = 2'd2,
      REASON_FAILSAFE = 2'd3
   } reason_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RING_CAPACITY = 3'd0,
      CSR_NORMAL_PCT    = 3'd1,
      CSR_EMERG_PCT     = 3'd2,
      CSR_BACKOFF_MS    = 3'd3,
      CSR_FIRST_MS      = 3'd4,
      CSR_FAILSAFE_MS   = 3'd5,
      CSR_GPS_BLOCK     = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [BACKOFF_W-1:0] backoff_ms;
      logic [DL_W-1:0]      first_ms;
      logic [DL_W-1:0]      failsafe_ms;
      logic                 gps_block;
      logic [PROD_W-1:0]    prod_normal;
      logic [PROD_W-1:0]    prod_emerg;
   } cfg_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [TIME_W-1:0] now_ms;
      logic [USED_W-1:0] ring_used;
      logic [PROD_W-1:0] used_scaled;
      logic              gps_busy;
      logic              flush_complete;
      logic [REC_W-1:0]  records_written;
   } item_type;

   typedef struct packed {
      logic              flush_start;
      reason_type        flush_cause;
      logic [TIME_W-1:0] wait_ms;
      logic              gateway_active;
      logic              flush_pending;
   } result_type;

   // wrap-safe: target reached when (now - target) mod 2^32 < 2^31
   function automatic logic reached(input logic [TIME_W-1:0] now,
                                    input logic [TIME_W-1:0] target);
      logic [TIME_W-1:0] diff;
      diff = now - target;
      return ~diff[TIME_W-1];
   endfunction

   function automatic logic [TIME_W-1:0] deadline_wait(input logic [TIME_W-1:0] now,
                                                       input logic [TIME_W-1:0] target);
      logic [TIME_W-1:0] rem;
      rem = target - now;
      return reached(now, target) ? WAIT_NOW : rem;
   endfunction

endpackage

[hw/rtl/lfs_if.sv]
interface lfs_req_if;
   import lfs_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [TIME_W-1:0] now_ms;
   logic [USED_W-1:0] ring_used;
   logic              gps_busy;
   logic              flush_complete;
   logic [REC_W-1:0]  records_written;

   modport source (output valid, op, now_ms, ring_used, gps_busy, flush_complete,
                   records_written, input ready);
   modport sink (input valid, op, now_ms, ring_used, gps_busy, flush_complete,
                 records_written, output ready);
endinterface

interface lfs_rsp_if;
   import lfs_pkg::*;

   logic              valid;
   logic              ready;
   logic              flush_start;
   logic [1:0]        flush_cause;
   logic [TIME_W-1:0] wait_ms;
   logic              gateway_active;
   logic              flush_pending;

   modport source (output valid, flush_start, flush_cause, wait_ms, gateway_active,
                   flush_pending, input ready);
   modport sink (input valid, flush_start, flush_cause, wait_ms, gateway_active,
                 flush_pending, output ready);
endinterface

[hw/rtl/lfs_cfg.sv]
module lfs_cfg (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [lfs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lfs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output lfs_pkg::cfg_type                cfg
);
   import lfs_pkg::*;

   logic [CAP_W-1:0]     capacity_ff, capacity_in;
   logic [PCT_W-1:0]     normal_pct_ff, normal_pct_in;
   logic [PCT_W-1:0]     emerg_pct_ff, emerg_pct_in;
   logic [BACKOFF_W-1:0] backoff_ff, backoff_in;
   logic [DL_W-1:0]      first_ff, first_in;
   logic [DL_W-1:0]      failsafe_ff, failsafe_in;
   logic                 gps_block_ff, gps_block_in;
   logic [PROD_W-1:0]    prod_normal_ff, prod_normal_in;
   logic [PROD_W-1:0]    prod_emerg_ff, prod_emerg_in;

   always_comb begin
      capacity_in   = capacity_ff;
      normal_pct_in = normal_pct_ff;
      emerg_pct_in  = emerg_pct_ff;
      backoff_in    = backoff_ff;
      first_in      = first_ff;
      failsafe_in   = failsafe_ff;
      gps_block_in  = gps_block_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_RING_CAPACITY: capacity_in   = csr_wdata[CAP_W-1:0];
            CSR_NORMAL_PCT:    normal_pct_in = csr_wdata[PCT_W-1:0];
            CSR_EMERG_PCT:     emerg_pct_in  = csr_wdata[PCT_W-1:0];
            CSR_BACKOFF_MS:    backoff_in    = csr_wdata[BACKOFF_W-1:0];
            CSR_FIRST_MS:      first_in      = csr_wdata[DL_W-1:0];
            CSR_FAILSAFE_MS:   failsafe_in   = csr_wdata[DL_W-1:0];
            CSR_GPS_BLOCK:     gps_block_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // capacity*percent is formed from the next register values, so the
   // products change on the same edge as the registers themselves
   assign prod_normal_in = PROD_W'(capacity_in) * PROD_W'(normal_pct_in);
   assign prod_emerg_in  = PROD_W'(capacity_in) * PROD_W'(emerg_pct_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff    <= RST_RING_CAPACITY;
         normal_pct_ff  <= RST_NORMAL_PCT;
         emerg_pct_ff   <= RST_EMERG_PCT;
         backoff_ff     <= RST_BACKOFF_MS;
         first_ff       <= RST_FIRST_MS;
         failsafe_ff    <= RST_FAILSAFE_MS;
         gps_block_ff   <= 1'b0;
         prod_normal_ff <= RST_PROD_NORMAL;
         prod_emerg_ff  <= RST_PROD_EMERG;
      end else begin
         capacity_ff    <= capacity_in;
         normal_pct_ff  <= normal_pct_in;
         emerg_pct_ff   <= emerg_pct_in;
         backoff_ff     <= backoff_in;
         first_ff       <= first_in;
         failsafe_ff    <= failsafe_in;
         gps_block_ff   <= gps_block_in;
         prod_normal_ff <= prod_normal_in;
         prod_emerg_ff  <= prod_emerg_in;
      end
   end

   assign cfg.backoff_ms  = backoff_ff;
   assign cfg.first_ms    = first_ff;
   assign cfg.failsafe_ms = failsafe_ff;
   assign cfg.gps_block   = gps_block_ff;
   assign cfg.prod_normal = prod_normal_ff;
   assign cfg.prod_emerg  = prod_emerg_ff;

endmodule

[hw/rtl/lfs_core.sv]
module lfs_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  lfs_pkg::item_type   item,
   input  lfs_pkg::cfg_type    cfg,
   output lfs_pkg::result_type result
);
   import lfs_pkg::*;

   logic              gw_ff, gw_in;
   logic              pend_ff, pend_in;
   reason_type        reason_ff, reason_in;
   logic [TIME_W-1:0] retry_ff, retry_in;
   logic [TIME_W-1:0] last_ff, last_in;
   logic              first_done_ff, first_done_in;

   logic              waiting;
   logic              emerg_hit;
   logic              normal_hit;
   logic              first_due;
   logic              failsafe_due;
   logic              start;

   logic              backoff_next;
   logic [TIME_W-1:0] backoff_rem;
   logic [TIME_W-1:0] first_wait;
   logic [TIME_W-1:0] guard_wait;
   logic [TIME_W-1:0] deadline_min;
   logic [TIME_W-1:0] wait_ms;

   assign waiting = (cfg.backoff_ms != '0) && !reached(item.now_ms, retry_ff);

   // a threshold of zero (product below 100) never raises a request
   assign emerg_hit  = (cfg.prod_emerg >= PCT_SCALE) && (item.used_scaled >= cfg.prod_emerg);
   assign normal_hit = (cfg.prod_normal >= PCT_SCALE) && (item.used_scaled >= cfg.prod_normal);

   assign first_due    = !first_done_ff && (cfg.first_ms != '0) &&
                         reached(item.now_ms, last_ff + TIME_W'(cfg.first_ms));
   assign failsafe_due = (cfg.failsafe_ms != '0) &&
                         reached(item.now_ms, last_ff + TIME_W'(cfg.failsafe_ms));

   always_comb begin
      gw_in         = gw_ff;
      pend_in       = pend_ff;
      reason_in     = reason_ff;
      retry_in      = retry_ff;
      last_in       = last_ff;
      first_done_in = first_done_ff;
      start         = 1'b0;
      case (item.op)
         OP_TICK: begin
            if (!gw_ff && !waiting) begin
               if (emerg_hit) begin
                  pend_in   = 1'b1;
                  reason_in = REASON_EMERG;
               end else if (normal_hit && !(pend_ff && reason_ff == REASON_EMERG)) begin
                  pend_in   = 1'b1;
                  reason_in = REASON_NORMAL;
               end
               if ((item.ring_used != '0) && (first_due || failsafe_due) &&
                   !(pend_in && reason_in == REASON_EMERG)) begin
                  pend_in   = 1'b1;
                  reason_in = REASON_FAILSAFE;
               end
            end
            start = !gw_ff && !waiting && pend_in &&
                    !(cfg.gps_block && item.gps_busy && reason_in != REASON_EMERG);
         end
         OP_OUTCOME: begin
            if (item.flush_complete ||
                ((item.records_written != '0) && (item.used_scaled < cfg.prod_normal))) begin
               last_in       = item.now_ms;
               first_done_in = 1'b1;
            end
            if (item.flush_complete) begin
               pend_in = 1'b0;
            end
         end
         OP_WRITE_FAIL: begin
            retry_in = item.now_ms + TIME_W'(cfg.backoff_ms);
            pend_in  = 1'b0;
         end
         OP_GW_BEGIN: begin
            gw_in = 1'b1;
         end
         OP_GW_END: begin
            gw_in = 1'b0;
         end
         OP_GW_DRAINED: begin
            gw_in         = 1'b1;
            last_in       = item.now_ms;
            first_done_in = 1'b1;
            pend_in       = 1'b0;
         end
         default: ;
      endcase
   end

   // wait is taken from the state as it stands after this transaction
   assign backoff_next = (cfg.backoff_ms != '0) && !reached(item.now_ms, retry_in);
   assign backoff_rem  = retry_in - item.now_ms;
   assign first_wait   = deadline_wait(item.now_ms, last_in + TIME_W'(cfg.first_ms));
   assign guard_wait   = deadline_wait(item.now_ms, last_in + TIME_W'(cfg.failsafe_ms));

   always_comb begin
      deadline_min = WAIT_NEVER;
      if (!first_done_in && (cfg.first_ms != '0)) begin
         deadline_min = first_wait;
      end
      if ((cfg.failsafe_ms != '0) && (guard_wait < deadline_min)) begin
         deadline_min = guard_wait;
      end
      if (gw_in) begin
         wait_ms = WAIT_NEVER;
      end else if (pend_in) begin
         wait_ms = WAIT_NOW;
      end else if (backoff_next) begin
         wait_ms = (backoff_rem > WAIT_NOW) ? backoff_rem : WAIT_NOW;
      end else begin
         wait_ms = deadline_min;
      end
   end

   assign result.flush_start    = start;
   assign result.flush_cause    = pend_in ? reason_in : REASON_NONE;
   assign result.wait_ms        = wait_ms;
   assign result.gateway_active = gw_in;
   assign result.flush_pending  = pend_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         gw_ff         <= 1'b0;
         pend_ff       <= 1'b0;
         reason_ff     <= REASON_NORMAL;
         retry_ff      <= '0;
         last_ff       <= '0;
         first_done_ff <= 1'b0;
      end else if (fire) begin
         gw_ff         <= gw_in;
         pend_ff       <= pend_in;
         reason_ff     <= reason_in;
         retry_ff      <= retry_in;
         last_ff       <= last_in;
         first_done_ff <= first_done_in;
      end
   end

endmodule

[hw/rtl/log_flush_scheduler.sv]
// Log flush scheduler.
// req_ch takes one transaction per operation (service tick, flush outcome,
// write failure, gateway begin/end/drained) with the current uptime and ring
// fill. rsp_ch returns exactly one transaction per request: flush_start, the
// pending reason, the wait until the next deadline and the gateway/pending
// flags after the operation.
// csr_we/csr_index/csr_wdata write the scheduler registers; write them only
// while no transaction is in flight.
// A request is registered in the input register, passes once through the
// update logic and is registered again in the response register.
// Throughput: one transaction per cycle while the receiver takes responses;
// the input register takes one request while a response waits, then holds it.
// Reset (synchronous, active high) restores the register defaults, clears
// the gateway and pending flags and empties both pipeline registers.
// When the receiver stalls, the response holds, the input register fills and
// req_ch.ready drops until the response is taken.
module log_flush_scheduler (
   input  logic                           clock,
   input  logic                           reset,
   lfs_req_if.sink                        req_ch,
   lfs_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [lfs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lfs_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lfs_pkg::*;
   `include "log_flush_scheduler_assert.svh"

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       item_valid_ff, item_valid_in;
   result_type rsp_ff, core_result;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       fire;

   lfs_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lfs_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   assign fire         = item_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   // nothing is taken while reset is held
   assign req_ch.ready = !reset && (!item_valid_ff || fire);
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      item_in                 = item_ff;
      item_in.op              = req_ch.op;
      item_in.now_ms          = req_ch.now_ms;
      item_in.ring_used       = req_ch.ring_used;
      // used*100 + 99, compared against capacity*percent
      item_in.used_scaled     = (PROD_W'(req_ch.ring_used) << 6) +
                                (PROD_W'(req_ch.ring_used) << 5) +
                                (PROD_W'(req_ch.ring_used) << 2) + PCT_ROUND;
      item_in.gps_busy        = req_ch.gps_busy;
      item_in.flush_complete  = req_ch.flush_complete;
      item_in.records_written = req_ch.records_written;
   end

   assign item_valid_in = accept ? 1'b1 : (fire ? 1'b0 : item_valid_ff);
   assign rsp_valid_in  = fire ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
      if (fire) begin
         rsp_ff <= core_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.flush_start    = rsp_ff.flush_start;
   assign rsp_ch.flush_cause    = rsp_ff.flush_cause;
   assign rsp_ch.wait_ms        = rsp_ff.wait_ms;
   assign rsp_ch.gateway_active = rsp_ff.gateway_active;
   assign rsp_ch.flush_pending  = rsp_ff.flush_pending;

   `LFS_ASSERT(a_start_needs_pending, clock, reset, (rsp_valid_ff && rsp_ff.flush_start |-> rsp_ff.flush_pending && rsp_ff.flush_cause != REASON_NONE), "flush_start without a pending request")
   `LFS_ASSERT(a_gateway_quiet, clock, reset, (rsp_valid_ff && rsp_ff.gateway_active |-> !rsp_ff.flush_start && rsp_ff.wait_ms == WAIT_NEVER), "activity reported during a gateway session")
   `LFS_ASSERT(a_held_item_advances, clock, reset, (item_valid_ff && !rsp_valid_ff |=> rsp_valid_ff), "buffered request did not produce a response")
   `LFS_ASSERT_ALWAYS(a_reset_empties, clock, (reset |=> !rsp_valid_ff && !item_valid_ff), "pipeline not empty after reset")

endmodule

[tb/sv/flush_schedule_check.sv]
`timescale 1ns / 1ps

module flush_schedule_check (
   input  logic                           clock,
   input  logic                           reset,
   lfs_req_if                             req_mon,
   lfs_rsp_if                             rsp_mon,
   input  logic                           csr_we,
   input  logic [lfs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lfs_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             mismatches,
   output int                             outstanding
);
   import lfs_pkg::*;

   localparam int          PCT_FULL    = 100;
   localparam int          SHOWN_LIMIT = 10;
   localparam logic [31:0] HALF_RANGE  = 32'h8000_0000;

   // register copies
   logic [CAP_W-1:0]     cap_bytes;
   logic [PCT_W-1:0]     pct_normal;
   logic [PCT_W-1:0]     pct_emerg;
   logic [BACKOFF_W-1:0] backoff_cfg;
   logic [DL_W-1:0]      first_cfg;
   logic [DL_W-1:0]      failsafe_cfg;
   logic                 gps_block;

   // scheduler state
   logic              gw_open;
   logic              req_pending;
   reason_type        req_reason;
   logic [TIME_W-1:0] retry_at;
   logic [TIME_W-1:0] last_flush;
   logic              first_done;

   result_type due_results[$];

   function automatic logic deadline_hit(logic [TIME_W-1:0] t, logic [TIME_W-1:0] target);
      logic [TIME_W-1:0] gap;
      gap = t - target;
      return gap < HALF_RANGE;
   endfunction

   function automatic logic [31:0] fill_threshold(logic [PCT_W-1:0] pct);
      logic [31:0] prod;
      prod = 32'(cap_bytes) * 32'(pct);
      return prod / PCT_FULL;
   endfunction

   function automatic logic backoff_active(logic [TIME_W-1:0] t);
      return backoff_cfg != '0 && !deadline_hit(t, retry_at);
   endfunction

   // an emergency request is never downgraded by a later one
   function automatic void raise_request(reason_type why);
      if (why == REASON_EMERG) begin
         req_pending = 1'b1;
         req_reason  = REASON_EMERG;
      end else if (!(req_pending && req_reason == REASON_EMERG)) begin
         req_pending = 1'b1;
         req_reason  = why;
      end
   endfunction

   function automatic logic [TIME_W-1:0] deadline_left(logic [TIME_W-1:0] t,
                                                       logic [TIME_W-1:0] target);
      return deadline_hit(t, target) ? WAIT_NOW : target - t;
   endfunction

   function automatic logic [TIME_W-1:0] next_wait(logic [TIME_W-1:0] t);
      logic [TIME_W-1:0] w;
      logic [TIME_W-1:0] f;
      logic [TIME_W-1:0] d;
      w = WAIT_NEVER;
      if (gw_open) return WAIT_NEVER;
      if (req_pending) return WAIT_NOW;
      if (backoff_active(t)) begin
         d = retry_at - t;
         return (d > WAIT_NOW) ? d : WAIT_NOW;
      end
      if (!first_done && first_cfg != '0)
         w = deadline_left(t, last_flush + 32'(first_cfg));
      if (failsafe_cfg != '0) begin
         f = deadline_left(t, last_flush + 32'(failsafe_cfg));
         if (f < w) w = f;
      end
      return w;
   endfunction

   function automatic logic service_tick(logic [TIME_W-1:0] t, logic [USED_W-1:0] used,
                                         logic gps);
      logic        held_off;
      logic [31:0] emerg_lvl;
      logic [31:0] normal_lvl;
      if (gw_open) return 1'b0;
      held_off = backoff_active(t);
      if (!held_off) begin
         emerg_lvl  = fill_threshold(pct_emerg);
         normal_lvl = fill_threshold(pct_normal);
         if (emerg_lvl != 0 && 32'(used) >= emerg_lvl)
            raise_request(REASON_EMERG);
         else if (normal_lvl != 0 && 32'(used) >= normal_lvl)
            raise_request(REASON_NORMAL);
         if (!first_done && first_cfg != '0 && used != '0 &&
             deadline_hit(t, last_flush + 32'(first_cfg)))
            raise_request(REASON_FAILSAFE);
         if (failsafe_cfg != '0 && used != '0 &&
             deadline_hit(t, last_flush + 32'(failsafe_cfg)))
            raise_request(REASON_FAILSAFE);
      end
      if (!req_pending) return 1'b0;
      if (gps_block && gps && req_reason != REASON_EMERG) return 1'b0;
      return !held_off;
   endfunction

   function automatic result_type forecast_result(logic [OP_W-1:0] op, logic [TIME_W-1:0] t,
                                                  logic [USED_W-1:0] used, logic gps,
                                                  logic done, logic [REC_W-1:0] wrote);
      result_type r;
      r.flush_start = 1'b0;
      case (op)
         OP_TICK: r.flush_start = service_tick(t, used, gps);
         OP_OUTCOME: begin
            if (done || (wrote != '0 && 32'(used) < fill_threshold(pct_normal))) begin
               last_flush = t;
               first_done = 1'b1;
            end
            if (done) req_pending = 1'b0;
         end
         OP_WRITE_FAIL: begin
            retry_at    = t + 32'(backoff_cfg);
            req_pending = 1'b0;
         end
         OP_GW_BEGIN: gw_open = 1'b1;
         OP_GW_END: gw_open = 1'b0;
         OP_GW_DRAINED: begin
            gw_open     = 1'b1;
            last_flush  = t;
            first_done  = 1'b1;
            req_pending = 1'b0;
         end
         default: ;
      endcase
      r.flush_cause    = req_pending ? req_reason : REASON_NONE;
      r.wait_ms        = next_wait(t);
      r.gateway_active = gw_open;
      r.flush_pending  = req_pending;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         cap_bytes    = RST_RING_CAPACITY;
         pct_normal   = RST_NORMAL_PCT;
         pct_emerg    = RST_EMERG_PCT;
         backoff_cfg  = RST_BACKOFF_MS;
         first_cfg    = RST_FIRST_MS;
         failsafe_cfg = RST_FAILSAFE_MS;
         gps_block    = 1'b0;
         gw_open      = 1'b0;
         req_pending  = 1'b0;
         req_reason   = REASON_NORMAL;
         retry_at     = '0;
         last_flush   = '0;
         first_done   = 1'b0;
         due_results.delete();
         mismatches   = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_RING_CAPACITY: cap_bytes    = csr_wdata[CAP_W-1:0];
               CSR_NORMAL_PCT:    pct_normal   = csr_wdata[PCT_W-1:0];
               CSR_EMERG_PCT:     pct_emerg    = csr_wdata[PCT_W-1:0];
               CSR_BACKOFF_MS:    backoff_cfg  = csr_wdata[BACKOFF_W-1:0];
               CSR_FIRST_MS:      first_cfg    = csr_wdata[DL_W-1:0];
               CSR_FAILSAFE_MS:   failsafe_cfg = csr_wdata[DL_W-1:0];
               CSR_GPS_BLOCK:     gps_block    = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            due_results.push_back(forecast_result(req_mon.op, req_mon.now_ms,
                                                  req_mon.ring_used, req_mon.gps_busy,
                                                  req_mon.flush_complete,
                                                  req_mon.records_written));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_results.size() == 0) begin
               mismatches++;
               if (mismatches <= SHOWN_LIMIT)
                  $display("%0t: unexpected result transaction start %0b reason %0d wait %0h",
                           $realtime, rsp_mon.flush_start, rsp_mon.flush_cause,
                           rsp_mon.wait_ms);
            end else begin
               want = due_results.pop_front();
               if (want.flush_start !== rsp_mon.flush_start ||
                   want.flush_cause !== rsp_mon.flush_cause ||
                   want.wait_ms !== rsp_mon.wait_ms ||
                   want.gateway_active !== rsp_mon.gateway_active ||
                   want.flush_pending !== rsp_mon.flush_pending) begin
                  mismatches++;
                  if (mismatches <= SHOWN_LIMIT)
                     $display({"%0t: mismatch exp start %0b reason %0d wait %0h gw %0b pend %0b",
                               " / got start %0b reason %0d wait %0h gw %0b pend %0b"},
                              $realtime, want.flush_start, want.flush_cause, want.wait_ms,
                              want.gateway_active, want.flush_pending,
                              rsp_mon.flush_start, rsp_mon.flush_cause, rsp_mon.wait_ms,
                              rsp_mon.gateway_active, rsp_mon.flush_pending);
               end
            end
         end
      end
      outstanding = due_results.size();
   end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import lfs_pkg::*;

   // codes outside the defined operation set
   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 235;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int          mismatches;
   int          outstanding;
   int          send_idle;
   int          recv_stall;
   int          fill;
   int          cap_basis;
   logic [31:0] uptime;

   lfs_req_if req_ch ();
   lfs_rsp_if rsp_ch ();

   log_flush_scheduler dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   flush_schedule_check flush_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   initial begin
      #2_000_000;
      $display("log_flush_scheduler regression: fail");
      $finish;
   end

   // result side back-pressure
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready = ($urandom_range(99) >= recv_stall);
      end
   end

   task automatic drive_req(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] t,
                            input logic [USED_W-1:0] used, input logic gps,
                            input logic done, input logic [REC_W-1:0] wrote);
      while ($urandom_range(99) < send_idle) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid           = 1'b1;
      req_ch.op              = op;
      req_ch.now_ms          = t;
      req_ch.ring_used       = used;
      req_ch.gps_busy        = gps;
      req_ch.flush_complete  = done;
      req_ch.records_written = wrote;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   // wait until every transaction in flight has been answered
   task automatic settle();
      req_ch.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic apply_setting(input int k);
      logic [CAP_W-1:0]     cap;
      logic [PCT_W-1:0]     pn;
      logic [PCT_W-1:0]     pe;
      logic [BACKOFF_W-1:0] bo;
      logic [DL_W-1:0]      ff;
      logic [DL_W-1:0]      fs;
      logic                 gb;
      case (k)
         0: begin
            cap = 16'd4096; pn = 7'd50; pe = 7'd90;
            bo = 20'd300; ff = 27'd500; fs = 27'd2000; gb = 1'b1;
         end
         1: begin
            cap = 16'hFFFF; pn = 7'd100; pe = 7'd100;
            bo = 20'd600000; ff = 27'd86400000; fs = 27'd86400000; gb = 1'b0;
         end
         2: begin
            cap = '0; pn = '0; pe = '0; bo = '0; ff = '0; fs = '0; gb = 1'b1;
         end
         default: begin
            cap = ($urandom_range(3) == 0) ? CAP_W'($urandom_range(0, 65535))
                                           : CAP_W'($urandom_range(64, 8192));
            pn  = PCT_W'($urandom_range(0, 100));
            pe  = PCT_W'($urandom_range(0, 100));
            bo  = ($urandom_range(3) == 0) ? BACKOFF_W'($urandom_range(0, 600000))
                                           : BACKOFF_W'($urandom_range(0, 3000));
            ff  = ($urandom_range(3) == 0) ? DL_W'($urandom_range(0, 86400000))
                                           : DL_W'($urandom_range(0, 6000));
            fs  = ($urandom_range(3) == 0) ? DL_W'($urandom_range(0, 86400000))
                                           : DL_W'($urandom_range(0, 12000));
            if ($urandom_range(4) == 0) bo = '0;
            if ($urandom_range(2) == 0) ff = '0;
            if ($urandom_range(4) == 0) fs = '0;
            gb  = 1'($urandom_range(1));
         end
      endcase
      write_reg(CSR_RING_CAPACITY, CSR_DATA_W'(cap));
      write_reg(CSR_NORMAL_PCT, CSR_DATA_W'(pn));
      write_reg(CSR_EMERG_PCT, CSR_DATA_W'(pe));
      write_reg(CSR_BACKOFF_MS, CSR_DATA_W'(bo));
      write_reg(CSR_FIRST_MS, CSR_DATA_W'(ff));
      write_reg(CSR_FAILSAFE_MS, CSR_DATA_W'(fs));
      write_reg(CSR_GPS_BLOCK, CSR_DATA_W'(gb));
      cap_basis = (cap == '0) ? 4096 : int'(cap);
   endtask

   task automatic random_item(input int span);
      int                r;
      int                rr;
      logic [OP_W-1:0]   op;
      logic [USED_W-1:0] used;
      logic              done;
      logic [REC_W-1:0]  wrote;
      r    = $urandom_range(99);
      done = 1'($urandom_range(1));
      rr   = $urandom_range(19);
      if (rr < 5) wrote = '0;
      else if (rr == 19) wrote = REC_W'($urandom_range(0, 65535));
      else wrote = REC_W'($urandom_range(1, 300));
      // mostly monotonic time, now and then a jump anywhere (wrap included)
      if ($urandom_range(49) == 0) uptime = $urandom;
      else uptime += $urandom_range(0, span);
      if (r < 56) begin
         op   = OP_TICK;
         fill = fill + $urandom_range(0, cap_basis / 5);
         if (fill > 65535) fill = 65535;
      end else if (r < 71) begin
         op = OP_OUTCOME;
         if (done) fill = 0;
         else fill = fill - $urandom_range(0, fill);
      end else if (r < 79) op = OP_WRITE_FAIL;
      else if (r < 83) op = OP_GW_BEGIN;
      else if (r < 94) op = OP_GW_END;
      else if (r < 97) begin
         op   = OP_GW_DRAINED;
         fill = 0;
      end else op = ($urandom_range(1) == 0) ? OP_SPARE_A : OP_SPARE_B;
      used = ($urandom_range(11) == 0) ? USED_W'($urandom_range(0, 65535)) : USED_W'(fill);
      drive_req(op, uptime, used, ($urandom_range(2) == 0), done, wrote);
   endtask

   initial begin
      int span;
      reset                  = 1'b1;
      csr_we                 = 1'b0;
      csr_index              = '0;
      csr_wdata              = '0;
      req_ch.valid           = 1'b0;
      req_ch.op              = '0;
      req_ch.now_ms          = '0;
      req_ch.ring_used       = '0;
      req_ch.gps_busy        = 1'b0;
      req_ch.flush_complete  = 1'b0;
      req_ch.records_written = '0;
      send_idle              = 0;
      recv_stall             = 0;
      fill                   = 0;
      cap_basis              = 4096;
      uptime                 = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // directed part on reset settings
      drive_req(OP_TICK, 32'd0, 16'd0, 1'b0, 1'b0, 16'd0);
      drive_req(OP_TICK, 32'd10, 16'd2047, 1'b0, 1'b0, 16'd0);
      drive_req(OP_TICK, 32'd20, 16'd2048, 1'b0, 1'b0, 16'd0);      // normal level exactly
      drive_req(OP_TICK, 32'd30, 16'd3686, 1'b0, 1'b0, 16'd0);      // emergency level exactly
      drive_req(OP_TICK, 32'd40, 16'd2048, 1'b0, 1'b0, 16'd0);      // must not downgrade
      drive_req(OP_OUTCOME, 32'd50, 16'd0, 1'b0, 1'b1, 16'hFFFF);
      drive_req(OP_OUTCOME, 32'd60, 16'd100, 1'b0, 1'b0, 16'd3);     // partial, below level
      drive_req(OP_OUTCOME, 32'd70, 16'd3000, 1'b0, 1'b0, 16'd0);
      drive_req(OP_WRITE_FAIL, 32'd1000, 16'd0, 1'b0, 1'b0, 16'd0);
      drive_req(OP_TICK, 32'd2000, 16'hFFFF, 1'b1, 1'b0, 16'd0);     // backoff running
      drive_req(OP_TICK, 32'd6000, 16'd4000, 1'b0, 1'b0, 16'd0);
      drive_req(OP_GW_BEGIN, 32'd6100, 16'd0, 1'b0, 1'b0, 16'd0);
      drive_req(OP_TICK, 32'd6200, 16'hFFFF, 1'b0, 1'b0, 16'd0);     // ignored in session
      drive_req(OP_OUTCOME, 32'd6250, 16'd0, 1'b0, 1'b1, 16'd1);     // outcome inside session
      drive_req(OP_GW_END, 32'd6300, 16'd0, 1'b0, 1'b0, 16'd0);
      drive_req(OP_GW_DRAINED, 32'd7000, 16'd0, 1'b0, 1'b0, 16'd0);
      drive_req(OP_GW_END, 32'd7100, 16'd0, 1'b0, 1'b0, 16'd0);
      drive_req(OP_TICK, 32'd3606999, 16'd1, 1'b0, 1'b0, 16'd0);     // failsafe one short
      drive_req(OP_TICK, 32'd3607000, 16'd1, 1'b0, 1'b0, 16'd0);     // failsafe due
      drive_req(OP_SPARE_A, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF);
      drive_req(OP_SPARE_B, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF);
      drive_req(OP_WRITE_FAIL, 32'hFFFF_F000, 16'd0, 1'b0, 1'b0, 16'd0); // retry time wraps
      drive_req(OP_TICK, 32'h0000_0100, 16'd4000, 1'b0, 1'b0, 16'd0);
      drive_req(OP_TICK, 32'd1000, 16'd2100, 1'b1, 1'b0, 16'd0);
      drive_req(OP_OUTCOME, 32'd1010, 16'd0, 1'b0, 1'b1, 16'd0);

      for (int seg = 0; seg < PHASES; seg++) begin
         settle();
         apply_setting(seg);
         case (seg % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 50; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 50; end
            default: begin send_idle = 6; recv_stall = 6; end
         endcase
         span = (seg % 3 == 0) ? 50 : ((seg % 3 == 1) ? 500 : 4000);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) random_item(span);
      end

      settle();
      repeat (3) @(negedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("log_flush_scheduler regression: pass");
      else
         $display("log_flush_scheduler regression: fail");
      $finish;
   end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/lfs_pkg.sv
hw/rtl/lfs_if.sv
hw/rtl/lfs_cfg.sv
hw/rtl/lfs_core.sv
hw/rtl/log_flush_scheduler.sv
tb/sv/flush_schedule_check.sv
tb/sv/testbench.sv
